// File: hw/rtl/crta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crta_pkg;

    localparam int COORD_W     = 11;
    localparam int RADIUS_W    = 10;
    localparam int COLOR_W     = 4;
    localparam int ORIGIN_W    = 10;
    localparam int STEP_X_W    = 11;
    localparam int STEP_Y_W    = 12;
    localparam int DECISION_W  = 16;
    localparam int PIXEL_W     = 13;

    localparam int S_FIELDS_W  = 2 * COORD_W + RADIUS_W + 1 + COLOR_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = 2 * PIXEL_W + COLOR_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic ALG_MIDPOINT  = 1'b0;
    localparam logic ALG_BRESENHAM = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 1'b1;

    localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET = 10'd400;
    localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET = 10'd300;

    typedef struct packed {
        logic [STEP_X_W-1:0]        point_a;
        logic signed [STEP_Y_W-1:0] point_b;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic [COLOR_W-1:0]         color;
        logic                       final_set;
    } job_t;

endpackage

`default_nettype wire

// File: hw/rtl/circle_rasterizer_two_algorithms_top.sv
// An item's first pixel is registered in the queue, then in the output register.
// Each emitting item gives eight pixels, one per cycle unless the output stalls.
// A step that arrives with no circle active is taken and emits nothing.
// Reset is synchronous and active low; it clears the circle state, the queue and the
// output, and sets the origin registers to column 400 and row 300.
`timescale 1ns / 1ps
`default_nettype none

module circle_rasterizer_two_algorithms_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [crta_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [crta_pkg::ORIGIN_W-1:0]         cfg_wr_data,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // center_x, center_y, radius, algorithm, color, zero fill
    input  wire logic [crta_pkg::S_TDATA_W-1:0]        s_tdata,
    // operation
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [crta_pkg::M_TDATA_W-1:0]             m_tdata,
    output logic                                       m_tlast
);

    logic           push_valid, push_ready, pop_valid, pop_ready;
    crta_pkg::job_t push_job, pop_job;

    crta_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    crta_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    crta_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .job_valid   (pop_valid),
        .job_ready   (pop_ready),
        .job         (pop_job),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// File: hw/rtl/crta_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module crta_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire crta_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output crta_pkg::job_t     pop_job
);

    crta_pkg::job_t                       entry_reg [crta_pkg::QUEUE_DEPTH];
    logic [crta_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [crta_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [crta_pkg::QUEUE_CNT_W-1:0]     count_reg, count_next;
    logic                                 do_push, do_pop;

    assign push_ready = (count_reg != crta_pkg::QUEUE_CNT_W'(crta_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            if (wr_ptr_reg == crta_pkg::QUEUE_PTR_W'(crta_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == crta_pkg::QUEUE_PTR_W'(crta_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/crta_front.sv
`timescale 1ns / 1ps
`default_nettype none

module crta_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // center_x, center_y, radius, algorithm, color, zero fill
    input  wire logic [crta_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation
    input  wire logic                              s_tuser,
    output logic                                   job_valid,
    input  wire logic                              job_ready,
    output crta_pkg::job_t                         job
);

    localparam int CY_LO  = crta_pkg::COORD_W;
    localparam int RAD_LO = 2 * crta_pkg::COORD_W;
    localparam int ALG_LO = RAD_LO + crta_pkg::RADIUS_W;
    localparam int COL_LO = ALG_LO + 1;
    localparam int DW     = crta_pkg::DECISION_W;

    logic                                   busy_reg, busy_next;
    logic                                   bres_reg, bres_next;
    logic [crta_pkg::STEP_X_W-1:0]          x_reg, x_next;
    logic signed [crta_pkg::STEP_Y_W-1:0]   y_reg, y_next;
    logic signed [DW-1:0]                   d_reg, d_next;
    logic signed [crta_pkg::COORD_W-1:0]    cx_reg, cx_next;
    logic signed [crta_pkg::COORD_W-1:0]    cy_reg, cy_next;
    logic [crta_pkg::COLOR_W-1:0]           color_reg, color_next;

    logic                                   take, is_start;
    logic [crta_pkg::RADIUS_W-1:0]          in_radius;
    logic                                   in_bres;
    logic signed [DW-1:0]                   r16, x16, y16;
    logic [crta_pkg::STEP_X_W-1:0]          x_inc;
    logic signed [crta_pkg::STEP_Y_W-1:0]   y_dec;
    logic signed [crta_pkg::STEP_Y_W-1:0]   x_cmp;
    logic                                   cont;

    assign s_tready  = job_ready;
    assign take      = s_tvalid && s_tready;
    assign is_start  = (s_tuser == crta_pkg::OP_START);
    assign in_radius = s_tdata[ALG_LO-1:RAD_LO];
    assign in_bres   = (s_tdata[ALG_LO] == crta_pkg::ALG_BRESENHAM);
    assign r16       = $signed({{(DW - crta_pkg::RADIUS_W){1'b0}}, in_radius});
    assign x_inc     = x_reg + 1'b1;
    assign y_dec     = y_reg - crta_pkg::STEP_Y_W'(1);

    always_comb begin
        busy_next  = busy_reg;
        bres_next  = bres_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        d_next     = d_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        x16        = '0;
        y16        = '0;
        if (is_start) begin
            bres_next  = in_bres;
            cx_next    = $signed(s_tdata[CY_LO-1:0]);
            cy_next    = $signed(s_tdata[RAD_LO-1:CY_LO]);
            color_next = s_tdata[COL_LO+crta_pkg::COLOR_W-1:COL_LO];
            x_next     = '0;
            y_next     = $signed({{(crta_pkg::STEP_Y_W - crta_pkg::RADIUS_W){1'b0}}, in_radius});
            if (in_bres) begin
                d_next = DW'(3) - (r16 <<< 1);
            end else begin
                d_next = DW'(1) - r16;
            end
        end else begin
            x_next = x_inc;
            x16    = $signed({{(DW - crta_pkg::STEP_X_W){1'b0}}, x_inc});
            if (bres_reg) begin
                if (d_reg > 0) begin
                    y_next = y_dec;
                    y16    = DW'(y_dec);
                    d_next = d_reg + ((x16 - y16) <<< 2) + DW'(10);
                end else begin
                    d_next = d_reg + (x16 <<< 2) + DW'(6);
                end
            end else begin
                if (d_reg < 0) begin
                    d_next = d_reg + (x16 <<< 1) + DW'(1);
                end else begin
                    y_next = y_dec;
                    y16    = DW'(y_dec);
                    d_next = d_reg + ((x16 - y16) <<< 1) + DW'(1);
                end
            end
        end
        x_cmp = $signed({1'b0, x_next});
        if (bres_next) begin
            cont = (y_next >= x_cmp);
        end else begin
            cont = (x_cmp < y_next);
        end
        busy_next = cont;
    end

    assign job_valid     = s_tvalid && (is_start || busy_reg);
    assign job.point_a   = x_next;
    assign job.point_b   = y_next;
    assign job.center_x  = cx_next;
    assign job.center_y  = cy_next;
    assign job.color     = color_next;
    assign job.final_set = !busy_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            bres_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            d_reg     <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
        end else if (take && (is_start || busy_reg)) begin
            busy_reg  <= busy_next;
            bres_reg  <= bres_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            d_reg     <= d_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            color_reg <= color_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/crta_back.sv
`timescale 1ns / 1ps
`default_nettype none

module crta_back (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [crta_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [crta_pkg::ORIGIN_W-1:0]         cfg_wr_data,
    input  wire logic                                  job_valid,
    output logic                                       job_ready,
    input  wire crta_pkg::job_t                        job,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [crta_pkg::M_TDATA_W-1:0]             m_tdata,
    output logic                                       m_tlast
);

    localparam int PW = crta_pkg::PIXEL_W;

    logic [crta_pkg::ORIGIN_W-1:0]      origin_x_reg, origin_y_reg;
    logic [2:0]                         idx_reg, idx_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [crta_pkg::M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                               m_tlast_reg, m_tlast_next;

    logic                               out_free, emit;
    logic signed [PW-1:0]               a13, b13, cx13, cy13, u13, v13;
    logic signed [PW-1:0]               lx, ly, px, py;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = job_valid && out_free;
    assign job_ready = out_free && (idx_reg == 3'd7);

    assign a13  = $signed({{(PW - crta_pkg::STEP_X_W){1'b0}}, job.point_a});
    assign b13  = PW'(job.point_b);
    assign cx13 = PW'(job.center_x);
    assign cy13 = PW'(job.center_y);
    assign u13  = idx_reg[2] ? b13 : a13;
    assign v13  = idx_reg[2] ? a13 : b13;
    assign lx   = idx_reg[0] ? (cx13 - u13) : (cx13 + u13);
    assign ly   = idx_reg[1] ? (cy13 - v13) : (cy13 + v13);
    assign px   = lx + $signed({{(PW - crta_pkg::ORIGIN_W){1'b0}}, origin_x_reg});
    assign py   = $signed({{(PW - crta_pkg::ORIGIN_W){1'b0}}, origin_y_reg}) - ly;

    always_comb begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            idx_next      = idx_reg + 1'b1;
            m_tvalid_next = 1'b1;
            m_tdata_next  = crta_pkg::M_TDATA_W'({job.color, py, px});
            m_tlast_next  = job.final_set && (idx_reg == 3'd7);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= crta_pkg::ORIGIN_X_RESET;
            origin_y_reg <= crta_pkg::ORIGIN_Y_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                crta_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_wr_data;
                crta_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// File: hw/rtl/crta_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module crta_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [crta_pkg::M_TDATA_W-1:0]        m_tdata,
    input wire logic                                  m_tlast
);

    localparam int COL_LO = 2 * crta_pkg::PIXEL_W;

    logic [2:0]                   pix_cnt_reg;
    logic [crta_pkg::COLOR_W-1:0] last_color_reg;
    logic                         m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg <= '0;
        end else if (m_xfer) begin
            pix_cnt_reg <= pix_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_xfer) begin
            last_color_reg <= m_tdata[COL_LO+crta_pkg::COLOR_W-1:COL_LO];
        end
    end

    // The output register is empty in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A waiting result transaction is not withdrawn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // The last flag only ever closes a group of eight pixels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |-> (pix_cnt_reg == 3'd7))
        else $error("last flag inside a pixel group");

    // All eight pixels of one group carry the same color.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && (pix_cnt_reg != 3'd0))
        |-> (m_tdata[COL_LO+crta_pkg::COLOR_W-1:COL_LO] == last_color_reg))
        else $error("color changed inside a pixel group");

endmodule

bind circle_rasterizer_two_algorithms_top crta_checker u_crta_checker (.*);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import crta_pkg::*;

    typedef struct packed {
        logic [PIXEL_W-1:0] x;
        logic [PIXEL_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    typedef enum {CHK_MODEL, CHK_NONE, CHK_SAME} row_check_e;

    typedef struct {
        logic       op;
        int         cx;
        int         cy;
        int         radius;
        logic       alg;
        int         color;
        row_check_e chk;
        int         exp_x;
        int         exp_y;
        bit         exp_last;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ORIGIN_W-1:0]  cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    pixel_t pending_pixels[$];
    int     error_count;
    int     mismatch_count;
    int     source_idle_pct;
    int     sink_idle_pct;

    int          origin_col;
    int          origin_row;
    bit          circ_busy;
    bit          circ_bres;
    int          circ_x;
    int          circ_y;
    int          circ_decision;
    int          circ_cx;
    int          circ_cy;
    logic [3:0]  circ_color;

    stim_row_t directed_rows[23] = '{
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_NONE,  0,   0,   0},
        '{OP_START, 0,     0,     0,    ALG_MIDPOINT,  15, CHK_SAME,  400, 300, 1},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_NONE,  0,   0,   0},
        '{OP_START, 0,     0,     0,    ALG_BRESENHAM, 0,  CHK_SAME,  400, 300, 0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_NONE,  0,   0,   0},
        '{OP_START, 1023,  1023,  1023, ALG_MIDPOINT,  5,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  -1,    -1,    1023, ALG_BRESENHAM, 15, CHK_MODEL, 0,   0,   0},
        '{OP_START, -1024, -1024, 1023, ALG_BRESENHAM, 10, CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_START, -1,    -1,    5,    ALG_MIDPOINT,  3,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_START, 7,     -7,    3,    ALG_BRESENHAM, 9,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0},
        '{OP_STEP,  0,     0,     0,    ALG_MIDPOINT,  0,  CHK_MODEL, 0,   0,   0}
    };

    circle_rasterizer_two_algorithms_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic predict_circle(input logic op, input logic [COORD_W-1:0] cx,
                                  input logic [COORD_W-1:0] cy,
                                  input logic [RADIUS_W-1:0] radius, input logic alg,
                                  input logic [COLOR_W-1:0] color,
                                  output pixel_t px[8], output int n);
        int lx[8];
        int ly[8];
        int sx;
        int sy;
        if (op == OP_START) begin
            circ_cx = int'($signed(cx));
            circ_cy = int'($signed(cy));
            circ_bres = (alg == ALG_BRESENHAM);
            circ_color = color;
            circ_x = 0;
            circ_y = int'(radius);
            circ_decision = circ_bres ? 3 - 2 * circ_y : 1 - circ_y;
        end else begin
            if (!circ_busy) begin
                n = 0;
                return;
            end
            circ_x++;
            if (circ_bres) begin
                if (circ_decision > 0) begin
                    circ_y--;
                    circ_decision += 4 * (circ_x - circ_y) + 10;
                end else begin
                    circ_decision += 4 * circ_x + 6;
                end
            end else begin
                if (circ_decision < 0) begin
                    circ_decision += 2 * circ_x + 1;
                end else begin
                    circ_y--;
                    circ_decision += 2 * (circ_x - circ_y) + 1;
                end
            end
        end
        circ_busy = circ_bres ? (circ_y >= circ_x) : (circ_x < circ_y);
        lx = '{circ_cx + circ_x, circ_cx - circ_x, circ_cx + circ_x, circ_cx - circ_x,
               circ_cx + circ_y, circ_cx - circ_y, circ_cx + circ_y, circ_cx - circ_y};
        ly = '{circ_cy + circ_y, circ_cy + circ_y, circ_cy - circ_y, circ_cy - circ_y,
               circ_cy + circ_x, circ_cy + circ_x, circ_cy - circ_x, circ_cy - circ_x};
        for (int k = 0; k < 8; k++) begin
            sx = lx[k] + origin_col;
            sy = origin_row - ly[k];
            px[k].x = sx[PIXEL_W-1:0];
            px[k].y = sy[PIXEL_W-1:0];
            px[k].color = circ_color;
            px[k].last = (k == 7) && !circ_busy;
        end
        n = 8;
    endtask

    task automatic send_item(input logic op, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [RADIUS_W-1:0] radius,
                             input logic alg, input logic [COLOR_W-1:0] color,
                             input row_check_e chk, input int exp_x, input int exp_y,
                             input bit exp_last, output int n);
        pixel_t px[8];
        pixel_t typed;
        while ($urandom_range(99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, color, alg, radius, cy, cx};
        do @(posedge aclk); while (!s_tready);
        predict_circle(op, cx, cy, radius, alg, color, px, n);
        if (chk == CHK_NONE) begin
            n = 0;
        end
        for (int k = 0; k < n; k++) begin
            if (chk == CHK_SAME) begin
                typed.x = exp_x[PIXEL_W-1:0];
                typed.y = exp_y[PIXEL_W-1:0];
                typed.color = color;
                typed.last = (k == 7) && exp_last;
                pending_pixels.push_back(typed);
            end else begin
                pending_pixels.push_back(px[k]);
            end
        end
    endtask

    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_origin(input int col, input int row);
        drain_pixels();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ORIGIN_X;
        cfg_wr_data <= col[ORIGIN_W-1:0];
        @(posedge aclk);
        cfg_index <= REG_ORIGIN_Y;
        cfg_wr_data <= row[ORIGIN_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        origin_col = col;
        origin_row = row;
    endtask

    task automatic random_traffic(input int target);
        int done_items;
        int n;
        int steps;
        int step_cap;
        logic [RADIUS_W-1:0] radius;
        done_items = 0;
        while (done_items < target) begin
            if ($urandom_range(99) < 15) begin
                send_item(logic'($urandom_range(1)), COORD_W'($urandom), COORD_W'($urandom),
                          RADIUS_W'($urandom), logic'($urandom_range(1)),
                          COLOR_W'($urandom), CHK_MODEL, 0, 0, 0, n);
                done_items += (n != 0);
            end else begin
                radius = ($urandom_range(99) < 80) ? RADIUS_W'($urandom_range(40))
                                                   : RADIUS_W'($urandom);
                send_item(OP_START, COORD_W'($urandom), COORD_W'($urandom), radius,
                          logic'($urandom_range(1)), COLOR_W'($urandom), CHK_MODEL,
                          0, 0, 0, n);
                done_items++;
                step_cap = ($urandom_range(99) < 20) ? $urandom_range(1, 10) : 60;
                steps = 0;
                while (circ_busy && steps < step_cap) begin
                    send_item(OP_STEP, COORD_W'($urandom), COORD_W'($urandom),
                              RADIUS_W'($urandom), logic'($urandom_range(1)),
                              COLOR_W'($urandom), CHK_MODEL, 0, 0, 0, n);
                    done_items++;
                    steps++;
                end
                if (!circ_busy && $urandom_range(99) < 10) begin
                    send_item(OP_STEP, '0, '0, '0, ALG_MIDPOINT, '0, CHK_MODEL, 0, 0, 0, n);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[PIXEL_W-1:0];
            got.y = m_tdata[2*PIXEL_W-1:PIXEL_W];
            got.color = m_tdata[2*PIXEL_W+COLOR_W-1:2*PIXEL_W];
            got.last = m_tlast;
            if (pending_pixels.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected pixel x=%0d y=%0d color=%0d last=%0b",
                             $signed(got.x), $signed(got.y), got.color, got.last);
                end
            end else begin
                want = pending_pixels.pop_front();
                if (got != want) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("pixel mismatch: expected x=%0d y=%0d color=%0d last=%0b",
                                 $signed(want.x), $signed(want.y), want.color, want.last,
                                 ", got x=%0d y=%0d color=%0d last=%0b",
                                 $signed(got.x), $signed(got.y), got.color, got.last);
                    end
                end
            end
        end
    end

    initial begin
        int n;
        stim_row_t row;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wr_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        m_tready <= 1'b0;
        error_count = 0;
        mismatch_count = 0;
        source_idle_pct = 29;
        sink_idle_pct = 29;
        origin_col = int'(ORIGIN_X_RESET);
        origin_row = int'(ORIGIN_Y_RESET);
        circ_busy = 0;
        circ_bres = 0;
        circ_x = 0;
        circ_y = 0;
        circ_decision = 0;
        circ_cx = 0;
        circ_cy = 0;
        circ_color = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.op, COORD_W'(row.cx), COORD_W'(row.cy), RADIUS_W'(row.radius),
                      row.alg, COLOR_W'(row.color), row.chk, row.exp_x, row.exp_y,
                      row.exp_last, n);
        end

        write_origin(0, 0);
        random_traffic(105);

        // Back-to-back traffic with both sides always ready.
        source_idle_pct = 0;
        sink_idle_pct = 0;
        write_origin(1023, 1023);
        random_traffic(105);
        source_idle_pct = 29;
        sink_idle_pct = 29;

        write_origin(0, 1023);
        random_traffic(105);

        write_origin($urandom_range(1023), $urandom_range(1023));
        random_traffic(105);

        drain_pixels();
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
